### rtl/ahih_pkg.sv
`timescale 1ns / 1ps

package ahih_pkg;

	// fixed field widths of the item payloads
	localparam int START_W   = 20;
	localparam int BCOUNT_W  = 9;
	localparam int TIME_W    = 48;
	localparam int HSEL_W    = 2;
	localparam int BINIDX_W  = 16;
	localparam int STATUS_W  = 2;
	localparam int OUTCNT_W  = 32;

	// interval divider: 48-bit tick difference over ticks per bin
	localparam int TICKS_PER_BIN = 1000000;
	localparam int QUOT_W        = 29;

	localparam int KIND_W = 2;
	localparam int REC_W  = TIME_W + KIND_W;

	localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

	localparam logic OP_BLOCK   = 1'b0;
	localparam logic OP_READOUT = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_APPLIED = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_READOUT = 2'd2;

	typedef struct packed {
		logic                opcode;
		logic                is_write;
		logic [START_W-1:0]  start_block;
		logic [BCOUNT_W-1:0] block_count;
		logic [TIME_W-1:0]   timestamp;
		logic [HSEL_W-1:0]   hist_select;
		logic [BINIDX_W-1:0] bin_index;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OUTCNT_W-1:0] bin_count;
	} rsp_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BLK_RD,
		ST_BLK_CHK,
		ST_DIV,
		ST_HIST_RD,
		ST_HIST_UPD,
		ST_RDOUT,
		ST_RDOUT_CAP,
		ST_DONE
	} state_t;

endpackage

### rtl/ahih_div.sv
`timescale 1ns / 1ps

module ahih_div import ahih_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] dividend,
	output logic              done,
	output logic [QUOT_W-1:0] quotient
);

	// ticks per bin is 2^6 * 15625: drop six bits, then multiply by the rounded-up
	// reciprocal of 15625 and keep the top bits
	localparam int PRE_SHIFT = 6;
	localparam int ODD_DIV   = TICKS_PER_BIN >> PRE_SHIFT;
	localparam int Y_W       = TIME_W - PRE_SHIFT;
	localparam int ODD_BITS  = $clog2(ODD_DIV);
	localparam int RECIP_SH  = Y_W + ODD_BITS;
	localparam int M_W       = Y_W + 1;
	localparam int YL_W      = Y_W / 2;
	localparam int ML_W      = M_W - YL_W;
	localparam int OPB_W     = ML_W;
	localparam int PP_W      = YL_W + OPB_W;
	localparam int ACC_W     = Y_W + M_W;
	localparam logic [63:0]    RECIP_FULL =
		((64'd1 << RECIP_SH) + 64'(ODD_DIV - 1)) / 64'(ODD_DIV);
	localparam logic [M_W-1:0] RECIP      = M_W'(RECIP_FULL);
	localparam logic [1:0]     LAST_STEP  = 2'd3;

	logic             busy_q;
	logic             done_q;
	logic [1:0]       step_q;
	logic [Y_W-1:0]   y_q;
	logic [ACC_W-1:0] acc_q;
	logic [YL_W-1:0]  op_a;
	logic [OPB_W-1:0] op_b;
	logic [PP_W-1:0]  prod;
	logic [ACC_W-1:0] prod_sh;

	// one partial product per step: step bit 1 picks the upper dividend half,
	// step bit 0 the upper reciprocal half
	always_comb begin
		op_a = step_q[1] ? y_q[Y_W-1:YL_W] : y_q[YL_W-1:0];
		op_b = step_q[0] ? OPB_W'(RECIP[M_W-1:ML_W]) : RECIP[ML_W-1:0];
		prod = PP_W'(op_a) * PP_W'(op_b);
		case (step_q)
			2'd0:    prod_sh = ACC_W'(prod);
			2'd1:    prod_sh = ACC_W'(prod) << ML_W;
			2'd2:    prod_sh = ACC_W'(prod) << YL_W;
			2'd3:    prod_sh = ACC_W'(prod) << (YL_W + ML_W);
			default: prod_sh = ACC_W'(prod);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			y_q   <= dividend[TIME_W-1:PRE_SHIFT];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + prod_sh;
		end
	end

	assign done     = done_q;
	assign quotient = acc_q[RECIP_SH +: QUOT_W];

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("divider done held for more than one cycle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q && $past(busy_q))
		else $error("divider done without a finished run");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

endmodule

### rtl/access_hazard_interval_histogram.sv
// path from acceptance to rsp_valid: a dropped or empty request goes straight to done, a readout reads
// and captures its bin, and a block request reads each block's record; a block with an earlier access
// updates a histogram bin, after an interval divide unless the record is newer than the request (the
// interval divide is 4 passes through one shared multiplier); a full output register adds its wait
// throughput: one item at a time; the next item is taken once the previous one has left the sequencer,
// while its result may still wait in the output register
// reset: arst_n clears control; a clearing pass then zeroes both memories, with req_ready low
`timescale 1ns / 1ps

module access_hazard_interval_histogram import ahih_pkg::*; #(
	parameter int BLOCK_ADDR_BITS    = 20,
	parameter int NUM_BINS           = 65536,
	parameter int MAX_REQUEST_BLOCKS = 256,
	parameter int COUNT_BITS         = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	localparam int BIN_W   = $clog2(NUM_BINS);
	localparam int HADDR_W = BIN_W + HSEL_W;
	localparam int CLR_W   = (BLOCK_ADDR_BITS > HADDR_W) ? BLOCK_ADDR_BITS : HADDR_W;
	localparam int CLAMP   = (MAX_REQUEST_BLOCKS < 511) ? MAX_REQUEST_BLOCKS : 511;
	localparam logic [BCOUNT_W-1:0] COUNT_CLAMP = BCOUNT_W'(CLAMP);
	localparam logic [QUOT_W-1:0]   LAST_BIN    = QUOT_W'(NUM_BINS - 1);
	localparam logic [31:0]         BIN_LIMIT   = 32'(NUM_BINS);

	// memories: last access record per block, four interval histograms side by side
	logic [REC_W-1:0]      last_access [2**BLOCK_ADDR_BITS];
	logic [COUNT_BITS-1:0] hist_mem    [2**HADDR_W];

	state_t state_q, state_d;

	// control
	logic                       seen_q;
	logic [TIME_W-1:0]          last_ts_q;
	logic [CLR_W-1:0]           clr_q;
	logic                       rsp_valid_q;

	// item being worked
	logic [TIME_W-1:0]          ts_q;
	logic                       wr_q;
	logic [BLOCK_ADDR_BITS-1:0] addr_q;
	logic [BCOUNT_W-1:0]        remain_q;
	logic [HSEL_W-1:0]          hsel_q;
	logic [BIN_W-1:0]           bin_q;
	logic                       bin_ok_q;
	rsp_item_t                  res_q;
	rsp_item_t                  rsp_q;

	// memory ports
	logic                       la_re, la_we;
	logic [BLOCK_ADDR_BITS-1:0] la_raddr, la_waddr;
	logic [REC_W-1:0]           la_wdata, la_rdata_q;
	logic                       h_re, h_we;
	logic [HADDR_W-1:0]         h_raddr, h_waddr;
	logic [COUNT_BITS-1:0]      h_wdata, h_rdata_q;

	// decode of the fetched record
	logic [KIND_W-1:0]          rec_kind;
	logic [TIME_W-1:0]          rec_time;
	logic                       rec_live;
	logic [TIME_W:0]            diff;
	logic                       newer_rec;

	// request decode
	logic                       drop;
	logic [BCOUNT_W-1:0]        req_count;
	logic                       last_block;

	// interval divider
	logic                       div_start;
	logic                       div_done;
	logic [QUOT_W-1:0]          div_quot;
	logic [QUOT_W-1:0]          bin_clamped;

	assign rec_kind  = la_rdata_q[KIND_W-1:0];
	assign rec_time  = la_rdata_q[REC_W-1:KIND_W];
	assign rec_live  = (rec_kind == KIND_READ) || (rec_kind == KIND_WRITE);
	assign diff      = {1'b0, ts_q} - {1'b0, rec_time};
	// a record newer than the request counts in the last bin
	assign newer_rec = diff[TIME_W];

	assign drop       = seen_q && (req.timestamp < last_ts_q);
	assign req_count  = (req.block_count > COUNT_CLAMP) ? COUNT_CLAMP : req.block_count;
	assign last_block = remain_q == BCOUNT_W'(1);

	assign bin_clamped = (div_quot > LAST_BIN) ? LAST_BIN : div_quot;

	ahih_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff[TIME_W-1:0]),
		.done     (div_done),
		.quotient (div_quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					if (req.opcode == OP_READOUT) state_d = ST_RDOUT;
					else if (drop || req_count == '0) state_d = ST_DONE;
					else state_d = ST_BLK_RD;
				end
			end
			ST_BLK_RD: state_d = ST_BLK_CHK;
			ST_BLK_CHK: begin
				if (rec_live) state_d = newer_rec ? ST_HIST_RD : ST_DIV;
				else state_d = last_block ? ST_DONE : ST_BLK_RD;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_HIST_RD;
			end
			ST_HIST_RD:   state_d = ST_HIST_UPD;
			ST_HIST_UPD:  state_d = last_block ? ST_DONE : ST_BLK_RD;
			ST_RDOUT:     state_d = ST_RDOUT_CAP;
			ST_RDOUT_CAP: state_d = ST_DONE;
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// memory control and divider start
	always_comb begin
		la_re     = 1'b0;
		la_raddr  = addr_q;
		la_we     = 1'b0;
		la_waddr  = addr_q;
		la_wdata  = {ts_q, (wr_q ? KIND_WRITE : KIND_READ)};
		h_re      = 1'b0;
		h_raddr   = {hsel_q, bin_q};
		h_we      = 1'b0;
		h_waddr   = {hsel_q, bin_q};
		h_wdata   = (h_rdata_q == '1) ? h_rdata_q : h_rdata_q + COUNT_BITS'(1);
		div_start = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				la_we    = 1'b1;
				la_waddr = clr_q[BLOCK_ADDR_BITS-1:0];
				la_wdata = '0;
				h_we     = 1'b1;
				h_waddr  = clr_q[HADDR_W-1:0];
				h_wdata  = '0;
			end
			ST_BLK_RD: la_re = 1'b1;
			ST_BLK_CHK: begin
				// untouched block: only the record is written
				la_we     = !rec_live;
				div_start = rec_live && !newer_rec;
			end
			ST_HIST_RD: h_re = 1'b1;
			ST_HIST_UPD: begin
				h_we  = 1'b1;
				la_we = 1'b1;
			end
			ST_RDOUT: h_re = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (la_we) last_access[la_waddr] <= la_wdata;
	end

	always_ff @(posedge clk) begin
		if (la_re) la_rdata_q <= last_access[la_raddr];
	end

	always_ff @(posedge clk) begin
		if (h_we) hist_mem[h_waddr] <= h_wdata;
	end

	always_ff @(posedge clk) begin
		if (h_re) h_rdata_q <= hist_mem[h_raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			seen_q      <= 1'b0;
			last_ts_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_IDLE && req_valid && req.opcode == OP_BLOCK && !drop) begin
				seen_q    <= 1'b1;
				last_ts_q <= req.timestamp;
			end
			if (state_q == ST_DONE && (!rsp_valid_q || rsp_ready)) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ts_q     <= req.timestamp;
				wr_q     <= req.is_write;
				addr_q   <= BLOCK_ADDR_BITS'(req.start_block);
				remain_q <= req_count;
				hsel_q   <= req.hist_select;
				bin_q    <= BIN_W'(req.bin_index);
				bin_ok_q <= 32'(req.bin_index) < BIN_LIMIT;
				res_q.bin_count <= '0;
				if (req.opcode == OP_READOUT) res_q.status <= STATUS_READOUT;
				else if (drop) res_q.status <= STATUS_DROPPED;
				else res_q.status <= STATUS_APPLIED;
			end
			ST_BLK_CHK: begin
				// histogram: earlier kind in the high bit, this kind in the low bit
				hsel_q <= {rec_kind == KIND_WRITE, wr_q};
				if (newer_rec) bin_q <= BIN_W'(LAST_BIN);
				if (!rec_live) begin
					addr_q   <= addr_q + 1'b1;
					remain_q <= remain_q - 1'b1;
				end
			end
			ST_DIV: begin
				if (div_done) bin_q <= BIN_W'(bin_clamped);
			end
			ST_HIST_UPD: begin
				addr_q   <= addr_q + 1'b1;
				remain_q <= remain_q - 1'b1;
			end
			ST_RDOUT_CAP: begin
				res_q.bin_count <= bin_ok_q ? OUTCNT_W'(h_rdata_q) : '0;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) rsp_q <= res_q;
			end
			default: begin
			end
		endcase
	end

	assign req_ready = state_q == ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_time_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		$past(seen_q) |-> last_ts_q >= $past(last_ts_q))
		else $error("accepted request time went backwards");

	a_walk_has_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLK_RD || state_q == ST_BLK_CHK || state_q == ST_HIST_UPD)
		|-> remain_q != '0)
		else $error("block walk with no blocks left");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("interval divider finished outside its wait state");

	a_request_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STATUS_READOUT |-> rsp.bin_count == '0)
		else $error("block request item carries a bin count");

	a_no_hist_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		h_we |-> state_q == ST_CLEAR || state_q == ST_HIST_UPD)
		else $error("histogram written outside clear or update");

endmodule

### dv/tb_access_hazard_interval_histogram.sv
`timescale 1ns / 1ps

module tb_access_hazard_interval_histogram import ahih_pkg::*;;

	// block geometry, kept equal to the defaults of the block
	localparam int ADDR_BITS  = START_W;
	localparam int BINS       = 65536;
	localparam int MAX_BLOCKS = 256;
	localparam int CNT_BITS   = OUTCNT_W;

	// the clearing pass alone runs with no item moving, so the limit sits well above it
	localparam int unsigned QUIET_LIMIT = 3_000_000;
	localparam int          RANDOM_ITEMS = 1425;
	localparam int          TAIL_CYCLES  = 40;

	// readout selector: previous kind then current kind
	typedef enum logic [HSEL_W-1:0] {
		HIST_RAR,
		HIST_WAR,
		HIST_RAW,
		HIST_WAW
	} hist_sel_e;

	// one per-block record as the profiler keeps it
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TIME_W-1:0] stamp;
	} access_rec_t;

	// scoreboard: mirrors the profiler state and holds the replies still owed
	class interval_profile_board;
		access_rec_t                      block_rec [bit [START_W-1:0]];
		bit [CNT_BITS-1:0]                bin_tally [bit [HSEL_W+BINIDX_W-1:0]];
		bit [TIME_W-1:0]                  newest_stamp;
		bit                               stamp_seen;
		rsp_item_t                        awaited_outcomes [$];
		int unsigned                      mismatches;
		int unsigned                      applied;
		int unsigned                      dropped;
		int unsigned                      readouts;
		int unsigned                      busy_readouts;
		int unsigned                      blocks_walked;

		function int pending();
			return awaited_outcomes.size();
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		function void tally_interval(bit [HSEL_W-1:0] hsel, bit [TIME_W-1:0] now,
			bit [TIME_W-1:0] then);
			bit [TIME_W-1:0]                gap;
			bit [BINIDX_W-1:0]              bin;
			bit [HSEL_W+BINIDX_W-1:0]       key;
			if (now < then) begin
				bin = BINIDX_W'(BINS - 1);
			end else begin
				gap = (now - then) / TICKS_PER_BIN;
				bin = (gap > BINS - 1) ? BINIDX_W'(BINS - 1) : gap[BINIDX_W-1:0];
			end
			key = {hsel, bin};
			if (!bin_tally.exists(key))
				bin_tally[key] = '0;
			if (bin_tally[key] != '1)
				bin_tally[key]++;
		endfunction

		function void note_request(req_item_t it);
			rsp_item_t                      r;
			int                             n;
			bit [START_W-1:0]               blk;
			access_rec_t                    rec;
			bit [HSEL_W+BINIDX_W-1:0]       key;
			r.bin_count = '0;
			if (it.opcode == OP_READOUT) begin
				r.status = STATUS_READOUT;
				key = {it.hist_select, it.bin_index};
				if (bin_tally.exists(key))
					r.bin_count = bin_tally[key];
				readouts++;
				if (r.bin_count != 0)
					busy_readouts++;
			end else if (stamp_seen && it.timestamp < newest_stamp) begin
				r.status = STATUS_DROPPED;
				dropped++;
			end else begin
				r.status = STATUS_APPLIED;
				stamp_seen = 1'b1;
				newest_stamp = it.timestamp;
				n = (it.block_count > MAX_BLOCKS) ? MAX_BLOCKS : it.block_count;
				for (int i = 0; i < n; i++) begin
					// addresses wrap at the top of the block space
					blk = it.start_block + START_W'(i);
					if (block_rec.exists(blk)) begin
						rec = block_rec[blk];
						if (rec.kind == KIND_READ || rec.kind == KIND_WRITE)
							tally_interval({rec.kind == KIND_WRITE, it.is_write},
								it.timestamp, rec.stamp);
					end
					rec.kind = it.is_write ? KIND_WRITE : KIND_READ;
					rec.stamp = it.timestamp;
					block_rec[blk] = rec;
				end
				blocks_walked += n;
				applied++;
			end
			awaited_outcomes.push_back(r);
		endfunction

		task check_result(rsp_item_t got);
			rsp_item_t want;
			if (awaited_outcomes.size() == 0) begin
				report($sformatf("unexpected result status %0d count %0d",
					got.status, got.bin_count));
			end else begin
				want = awaited_outcomes.pop_front();
				if (got.status !== want.status)
					report($sformatf("status %0d, wanted %0d", got.status, want.status));
				if (got.bin_count !== want.bin_count)
					report($sformatf("bin count %0d, wanted %0d",
						got.bin_count, want.bin_count));
			end
		endtask

		task check_leftover();
			if (awaited_outcomes.size() != 0)
				report($sformatf("%0d results never arrived", awaited_outcomes.size()));
		endtask
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	interval_profile_board sb = new();

	// percent of stalled receiver cycles and of sender gaps per item; zero in the busy stretch
	int unsigned   idle_pct = 30;
	// latest in-order trace time handed out by the request generator
	bit [TIME_W-1:0] now_ticks;
	int unsigned   quiet_cycles;
	bit            moved;

	access_hazard_interval_histogram #(
		.BLOCK_ADDR_BITS(ADDR_BITS),
		.NUM_BINS(BINS),
		.MAX_REQUEST_BLOCKS(MAX_BLOCKS),
		.COUNT_BITS(CNT_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	// receiver side: random back-pressure, changed on the falling edge only
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= idle_pct);
	end

	// monitor on the rising edge: note accepted items first, then check results,
	// and count cycles in which neither side moves
	always @(posedge clk) begin
		moved = 1'b0;
		if (arst_n) begin
			if (req_valid === 1'b1 && req_ready === 1'b1) begin
				sb.note_request(req);
				moved = 1'b1;
			end
			if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
				sb.check_result(rsp);
				moved = 1'b1;
			end
		end
		if (moved) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", quiet_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	function req_item_t make_request(bit wr, bit [START_W-1:0] start,
		bit [BCOUNT_W-1:0] cnt, bit [TIME_W-1:0] stamp);
		req_item_t it;
		it.opcode = OP_BLOCK;
		it.is_write = wr;
		it.start_block = start;
		it.block_count = cnt;
		it.timestamp = stamp;
		// readout fields are ignored for block requests, so fill them with noise
		it.hist_select = HSEL_W'($urandom);
		it.bin_index = BINIDX_W'($urandom);
		return it;
	endfunction

	function req_item_t make_readout(hist_sel_e sel, bit [BINIDX_W-1:0] bin);
		req_item_t it;
		it.opcode = OP_READOUT;
		it.is_write = 1'($urandom);
		it.start_block = START_W'($urandom);
		it.block_count = BCOUNT_W'($urandom);
		it.timestamp = TIME_W'({$urandom, $urandom});
		it.hist_select = sel;
		it.bin_index = bin;
		return it;
	endfunction

	// mostly well-formed traffic: rising times over a hot region so that blocks
	// are revisited, with a few late items that must be dropped
	function req_item_t random_request();
		bit               wr;
		bit [START_W-1:0] start;
		bit [BCOUNT_W-1:0] cnt;
		bit [TIME_W-1:0]  stamp;
		int               r;
		wr = 1'($urandom_range(1));
		r = $urandom_range(99);
		if (r < 70)
			start = START_W'($urandom_range(255));
		else if (r < 80)
			start = START_W'(20'hFFFFF - $urandom_range(15));
		else
			start = START_W'($urandom);
		r = $urandom_range(99);
		if (r < 88)
			cnt = BCOUNT_W'($urandom_range(12, 1));
		else if (r < 96)
			cnt = BCOUNT_W'($urandom_range(64, 13));
		else if (r < 97)
			cnt = BCOUNT_W'($urandom_range(256, 200));
		else if (r < 99)
			cnt = '0;
		else
			cnt = BCOUNT_W'($urandom_range(511, 257));
		r = $urandom_range(99);
		if (r < 5 && now_ticks != 0) begin
			stamp = TIME_W'(64'({$urandom, $urandom}) % now_ticks);
		end else begin
			if (r < 45)
				now_ticks += $urandom_range(999_999);
			else if (r < 75)
				now_ticks += $urandom_range(20_000_000, 1_000_000);
			else if (r < 92)
				now_ticks += $urandom_range(400_000_000, 20_000_000);
			else if (r < 97)
				now_ticks += 48'd65_535_000_000 + $urandom; // lands in the last bin
			stamp = now_ticks;
		end
		return make_request(wr, start, cnt, stamp);
	endfunction

	function req_item_t random_readout();
		bit [BINIDX_W-1:0] bin;
		int                r;
		r = $urandom_range(99);
		if (r < 60)
			bin = BINIDX_W'($urandom_range(20));
		else if (r < 75)
			bin = '1;
		else
			bin = BINIDX_W'($urandom);
		return make_readout(hist_sel_e'($urandom_range(3)), bin);
	endfunction

	// present one item on the falling edge and hold it until taken;
	// sometimes leave a short gap afterwards
	task send_item(input req_item_t it);
		int gap;
		@(negedge clk);
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_ready !== 1'b1);
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(4, 1);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// sender holds off until every owed result has come back
	task wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		bit [TIME_W-1:0] far;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// directed part: walk blocks 0 and 1 through every pairing of kinds,
		// then the edge cases of order, size and address
		far = 48'd13_000_000 + 48'd70_000_000_000;
		send_item(make_readout(HIST_RAR, '0));
		send_item(make_request(1'b0, '0, 9'd1, '0));
		send_item(make_request(1'b0, '0, 9'd1, 48'd500_000));
		send_item(make_request(1'b1, '0, 9'd1, 48'd3_500_000));
		send_item(make_request(1'b0, '0, 9'd2, 48'd10_000_000));
		// equal time stamps are still in order
		send_item(make_request(1'b1, 20'd1, 9'd1, 48'd10_000_000));
		send_item(make_request(1'b1, 20'd1, 9'd1, 48'd12_000_000));
		// late item, must leave every store untouched
		send_item(make_request(1'b0, '0, 9'd4, 48'd11_999_999));
		// empty request only moves the time
		send_item(make_request(1'b1, 20'd5, '0, 48'd12_000_000));
		// run that wraps past the top address
		send_item(make_request(1'b1, 20'hFFFFE, 9'd4, 48'd13_000_000));
		// interval far beyond the last bin
		send_item(make_request(1'b0, '0, 9'd1, far));
		// oversized count is clamped to the largest request
		send_item(make_request(1'b1, 20'h100, '1, far + 48'd1_000_000));
		send_item(make_request(1'b0, 20'h100, 9'd257, far + 48'd3_000_000));
		send_item(make_request(1'b0, 20'h080, 9'd256, far + 48'd3_000_000));
		send_item(make_readout(HIST_RAR, '0));
		send_item(make_readout(HIST_WAR, '0));
		send_item(make_readout(HIST_WAR, 16'd3));
		send_item(make_readout(HIST_RAW, 16'd6));
		send_item(make_readout(HIST_WAW, 16'd2));
		send_item(make_readout(HIST_WAW, 16'd1));
		send_item(make_readout(HIST_RAW, '1));
		send_item(make_readout(HIST_RAW, 16'd2));
		send_item(make_readout(HIST_RAR, 16'd1));
		now_ticks = far + 48'd3_000_000;

		// random part, with one stretch where neither side idles
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idle_pct = (n >= 500 && n < 800) ? 0 : 30;
			if (n % 300 == 150)
				wait_drained();
			if ($urandom_range(99) < 25)
				send_item(random_readout());
			else
				send_item(random_request());
		end

		// closing items: the latest possible time, then one that falls behind it
		idle_pct = 30;
		send_item(make_request(1'b1, START_W'($urandom), 9'd3, '1));
		send_item(make_request(1'b0, START_W'($urandom), 9'd2, 48'd5));
		send_item(make_readout(HIST_RAW, '1));
		send_item(make_readout(HIST_WAW, '0));

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.check_leftover();

		$display("covered %0d applied requests over %0d blocks, %0d late requests dropped",
			sb.applied, sb.blocks_walked, sb.dropped);
		$display("covered %0d bin readouts, %0d of them non-zero",
			sb.readouts, sb.busy_readouts);
		if (sb.mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/ahih_pkg.sv
rtl/ahih_div.sv
rtl/access_hazard_interval_histogram.sv
dv/tb_access_hazard_interval_histogram.sv
